@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, constants and helper functions of the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  // width of the saturating length counters
  localparam int CNT_W = 32;
  // width of the decoded byte limit register
  localparam int CFG_W = 32;
  // width used to compare counters against the limit
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // results per source byte
  localparam int RES_MAX   = 4;
  localparam int RES_CNT_W = $clog2(RES_MAX + 1);

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // decoded values of the simple escapes
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_TAB = 8'h09;

  // surrogate ranges
  localparam logic [15:0] HI_SUR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SUR_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_SUR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SUR_LAST  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // digit positions that end a \u escape and a low surrogate escape
  localparam logic [2:0] HEX_END = 3'd4;
  localparam logic [2:0] LOW_END = 3'd6;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_NO_QUOTE     = 4'd1,
    ST_CONTROL      = 4'd2,
    ST_UNTERMINATED = 4'd3,
    ST_OPEN_ESCAPE  = 4'd4,
    ST_LIMIT        = 4'd5,
    ST_BAD_ESCAPE   = 4'd6,
    ST_SHORT_UNI    = 4'd7,
    ST_BAD_HEX      = 4'd8,
    ST_NO_LOW       = 4'd9,
    ST_BAD_LOW      = 4'd10,
    ST_LONE_LOW     = 4'd11
  } status_t;

  typedef enum logic {
    SCAN_IDLE,
    SCAN_STRING
  } scan_t;

  typedef enum logic [2:0] {
    DM_PLAIN,
    DM_ESC,
    DM_HEX,
    DM_LOW,
    DM_DEAD
  } dmode_t;

  typedef enum logic {
    KIND_BYTE,
    KIND_STATUS
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
  } res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]   count;
    res_t [RES_MAX-1:0]     item;
  } res_group_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]     count;
    logic [RES_MAX-1:0][7:0]  data;
  } utf8_t;

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      h.val = b[3:0];
    end else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)) begin
      // low nibble of a..f and A..F is 1..6
      h.val = b[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.data = '0;
    if (cp < 21'h80) begin
      u.count   = RES_CNT_W'(1);
      u.data[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      u.count   = RES_CNT_W'(2);
      u.data[0] = {3'b110, cp[10:6]};
      u.data[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.count   = RES_CNT_W'(3);
      u.data[0] = {4'b1110, cp[15:12]};
      u.data[1] = {2'b10, cp[11:6]};
      u.data[2] = {2'b10, cp[5:0]};
    end else begin
      u.count   = RES_CNT_W'(4);
      u.data[0] = {5'b11110, cp[20:18]};
      u.data[1] = {2'b10, cp[17:12]};
      u.data[2] = {2'b10, cp[11:6]};
      u.data[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

@@ sv/jsu_decode.sv @@
// ----------------------------------------------------------------------------
// jsu_decode
// per-byte scanner and escape decoder state, yields the results of one byte
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_decode import jsu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  logic             in_eos,
  input  logic             in_newdoc,
  input  logic [CFG_W-1:0] max_bytes,
  output res_group_t       res
);

  // state registers
  scan_t            scan,        scan_next;
  logic             raw_bs,      raw_bs_next;
  dmode_t           dm,          dm_next;
  logic [2:0]       hex_pos,     hex_pos_next;
  logic [15:0]      hex_acc,     hex_acc_next;
  logic [9:0]       high_sur,    high_sur_next;
  logic             has_esc,     has_esc_next;
  status_t          latched_err, latched_err_next;
  status_t          tent_err,    tent_err_next;
  logic [CNT_W-1:0] raw_len,     raw_len_next;
  logic [CNT_W-1:0] dec_len,     dec_len_next;
  logic [CNT_W-1:0] total,       total_next;

  // escape decoder outputs
  dmode_t      dec_dm;
  logic [2:0]  dec_pos;
  logic [15:0] dec_acc;
  logic [9:0]  dec_hs;
  status_t     dec_tent;
  status_t     dec_lat;
  utf8_t       dec_out;
  hex_t        hv;
  logic [2:0]  pos_inc;
  logic [20:0] cp;
  logic        emit_cp;
  logic        emit_lit;
  logic [7:0]  lit_byte;

  // string level helpers
  logic [CNT_W-1:0] total_base;
  logic [CNT_W:0]   dec_sum;
  logic [CNT_W:0]   total_sum;
  logic [CMP_W-1:0] max_x;
  logic [CMP_W-1:0] total_x;
  logic [CMP_W-1:0] raw_x;
  logic             over_limit;
  status_t          close_err;
  logic             clear;

  // escape decoding of one content byte
  always_comb begin
    dec_dm   = dm;
    dec_pos  = hex_pos;
    dec_acc  = hex_acc;
    dec_hs   = high_sur;
    dec_tent = tent_err;
    dec_lat  = latched_err;
    emit_cp  = 1'b0;
    emit_lit = 1'b0;
    lit_byte = in_byte;
    cp       = {5'd0, hex_acc};
    hv       = hex_value(in_byte);
    pos_inc  = hex_pos + 3'd1;
    unique case (dm)
      DM_PLAIN: begin
        if (in_byte == CH_BSLASH) begin
          dec_dm = DM_ESC;
        end else begin
          emit_lit = 1'b1;
        end
      end
      DM_ESC: begin
        dec_dm = DM_PLAIN;
        unique case (in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: emit_lit = 1'b1;
          CH_LB: begin emit_lit = 1'b1; lit_byte = CODE_BS;  end
          CH_LF: begin emit_lit = 1'b1; lit_byte = CODE_FF;  end
          CH_LN: begin emit_lit = 1'b1; lit_byte = CODE_LF;  end
          CH_LR: begin emit_lit = 1'b1; lit_byte = CODE_CR;  end
          CH_LT: begin emit_lit = 1'b1; lit_byte = CODE_TAB; end
          CH_LU: begin
            dec_dm   = DM_HEX;
            dec_pos  = 3'd0;
            dec_acc  = 16'd0;
            dec_tent = ST_OK;
          end
          default: begin
            dec_lat = ST_BAD_ESCAPE;
            dec_dm  = DM_DEAD;
          end
        endcase
      end
      DM_HEX: begin
        if (!hv.ok) begin
          if (tent_err == ST_OK) begin
            dec_tent = ST_BAD_HEX;
          end
        end else begin
          dec_acc = {hex_acc[11:0], hv.val};
        end
        dec_pos = pos_inc;
        if (pos_inc >= HEX_END) begin
          if (dec_tent != ST_OK) begin
            dec_lat = dec_tent;
            dec_dm  = DM_DEAD;
          end else if (dec_acc >= HI_SUR_FIRST && dec_acc <= HI_SUR_LAST) begin
            dec_hs  = dec_acc[9:0];
            dec_dm  = DM_LOW;
            dec_pos = 3'd0;
            dec_acc = 16'd0;
          end else if (dec_acc >= LO_SUR_FIRST && dec_acc <= LO_SUR_LAST) begin
            dec_lat = ST_LONE_LOW;
            dec_dm  = DM_DEAD;
          end else begin
            emit_cp = 1'b1;
            cp      = {5'd0, dec_acc};
            dec_dm  = DM_PLAIN;
          end
        end
      end
      DM_LOW: begin
        if ((hex_pos == 3'd0 && in_byte != CH_BSLASH) ||
            (hex_pos == 3'd1 && in_byte != CH_LU)) begin
          dec_lat = ST_NO_LOW;
          dec_dm  = DM_DEAD;
        end else begin
          if (hex_pos >= 3'd2) begin
            if (!hv.ok) begin
              if (tent_err == ST_OK) begin
                dec_tent = ST_BAD_LOW;
              end
            end else begin
              dec_acc = {hex_acc[11:0], hv.val};
            end
          end
          dec_pos = pos_inc;
          if (pos_inc >= LOW_END) begin
            if (dec_tent != ST_OK) begin
              dec_lat = dec_tent;
              dec_dm  = DM_DEAD;
            end else if (dec_acc < LO_SUR_FIRST || dec_acc > LO_SUR_LAST) begin
              dec_lat = ST_BAD_LOW;
              dec_dm  = DM_DEAD;
            end else begin
              emit_cp = 1'b1;
              cp      = SUPP_BASE + {1'b0, high_sur, dec_acc[9:0]};
              dec_dm  = DM_PLAIN;
            end
          end
        end
      end
      DM_DEAD: begin
      end
      default: begin
      end
    endcase

    dec_out = '0;
    if (emit_cp) begin
      dec_out = utf8_encode(cp);
    end else if (emit_lit) begin
      dec_out.count   = RES_CNT_W'(1);
      dec_out.data[0] = lit_byte;
    end
  end

  // limit check and running total at the closing quote
  always_comb begin
    total_base = in_newdoc ? '0 : total;
    max_x      = CMP_W'(max_bytes);
    total_x    = CMP_W'(total_base);
    raw_x      = CMP_W'(raw_len);
    over_limit = has_esc && ((total_x > max_x) || (raw_x > max_x - total_x));
    close_err  = latched_err;
    unique case (dm)
      DM_HEX:  close_err = ST_SHORT_UNI;
      DM_LOW:  close_err = ST_NO_LOW;
      DM_ESC:  close_err = ST_BAD_ESCAPE;
      default: close_err = latched_err;
    endcase
    total_sum = {1'b0, total_base} + {1'b0, dec_len};
    dec_sum   = {1'b0, dec_len} + (CNT_W + 1)'(dec_out.count);
  end

  // raw scan and next state
  always_comb begin
    scan_next        = scan;
    raw_bs_next      = raw_bs;
    dm_next          = dm;
    hex_pos_next     = hex_pos;
    hex_acc_next     = hex_acc;
    high_sur_next    = high_sur;
    has_esc_next     = has_esc;
    latched_err_next = latched_err;
    tent_err_next    = tent_err;
    raw_len_next     = raw_len;
    dec_len_next     = dec_len;
    total_next       = total_base;
    clear            = 1'b0;
    res              = '0;

    if (scan == SCAN_IDLE) begin
      if (!in_eos && in_byte == CH_QUOTE) begin
        scan_next = SCAN_STRING;
        clear     = 1'b1;
      end else begin
        res.count          = RES_CNT_W'(1);
        res.item[0].kind   = KIND_STATUS;
        res.item[0].status = ST_NO_QUOTE;
      end
    end else if (in_eos) begin
      res.count          = RES_CNT_W'(1);
      res.item[0].kind   = KIND_STATUS;
      res.item[0].status = raw_bs ? ST_OPEN_ESCAPE : ST_UNTERMINATED;
      scan_next          = SCAN_IDLE;
      clear              = 1'b1;
    end else if (raw_bs || (in_byte != CH_QUOTE && in_byte >= CH_SPACE)) begin
      raw_bs_next      = !raw_bs && (in_byte == CH_BSLASH);
      has_esc_next     = has_esc || (!raw_bs && (in_byte == CH_BSLASH));
      raw_len_next     = (raw_len == CNT_MAX) ? raw_len : raw_len + 1'b1;
      dm_next          = dec_dm;
      hex_pos_next     = dec_pos;
      hex_acc_next     = dec_acc;
      high_sur_next    = dec_hs;
      tent_err_next    = dec_tent;
      latched_err_next = dec_lat;
      dec_len_next     = dec_sum[CNT_W] ? CNT_MAX : dec_sum[CNT_W-1:0];
      res.count        = dec_out.count;
      for (int i = 0; i < RES_MAX; i++) begin
        res.item[i].kind   = KIND_BYTE;
        res.item[i].data   = dec_out.data[i];
        res.item[i].status = ST_OK;
      end
    end else if (in_byte == CH_QUOTE) begin
      res.count        = RES_CNT_W'(1);
      res.item[0].kind = KIND_STATUS;
      if (over_limit) begin
        res.item[0].status = ST_LIMIT;
      end else begin
        res.item[0].status = close_err;
        if (close_err == ST_OK && has_esc) begin
          total_next = total_sum[CNT_W] ? CNT_MAX : total_sum[CNT_W-1:0];
        end
      end
      scan_next = SCAN_IDLE;
      clear     = 1'b1;
    end else begin
      res.count          = RES_CNT_W'(1);
      res.item[0].kind   = KIND_STATUS;
      res.item[0].status = ST_CONTROL;
      scan_next          = SCAN_IDLE;
      clear              = 1'b1;
    end

    if (clear) begin
      raw_bs_next      = 1'b0;
      dm_next          = DM_PLAIN;
      hex_pos_next     = 3'd0;
      hex_acc_next     = 16'd0;
      high_sur_next    = 10'd0;
      has_esc_next     = 1'b0;
      latched_err_next = ST_OK;
      tent_err_next    = ST_OK;
      raw_len_next     = '0;
      dec_len_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan        <= SCAN_IDLE;
      raw_bs      <= 1'b0;
      dm          <= DM_PLAIN;
      hex_pos     <= 3'd0;
      hex_acc     <= 16'd0;
      high_sur    <= 10'd0;
      has_esc     <= 1'b0;
      latched_err <= ST_OK;
      tent_err    <= ST_OK;
      raw_len     <= '0;
      dec_len     <= '0;
      total       <= '0;
    end else if (step) begin
      scan        <= scan_next;
      raw_bs      <= raw_bs_next;
      dm          <= dm_next;
      hex_pos     <= hex_pos_next;
      hex_acc     <= hex_acc_next;
      high_sur    <= high_sur_next;
      has_esc     <= has_esc_next;
      latched_err <= latched_err_next;
      tent_err    <= tent_err_next;
      raw_len     <= raw_len_next;
      dec_len     <= dec_len_next;
      total       <= total_next;
    end
  end

  // a dead decoder always carries the fault that killed it
  `ASSERT_IMPLIES(a_dead_has_error, clk, rst, dm == DM_DEAD, latched_err != ST_OK)
  // a pending raw backslash marks the string as escaped
  `ASSERT_IMPLIES(a_bs_marks_escape, clk, rst, raw_bs, has_esc)
  // outside a string the per-string counters are clear
  `ASSERT_IMPLIES(a_idle_clean, clk, rst, scan == SCAN_IDLE,
                  (raw_len == '0) && (dec_len == '0) && (dm == DM_PLAIN))

endmodule

@@ sv/jsu_out_buf.sv @@
// ----------------------------------------------------------------------------
// jsu_out_buf
// result register holding the results of one byte, drained one per transfer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_out_buf import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_group_t group,
  input  logic       out_stall,
  output logic       out_valid,
  output res_t       head,
  output logic       last,
  output logic       can_load
);

  logic [RES_CNT_W-1:0] cnt;
  res_t                 q [RES_MAX];
  logic                 pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = q[0];
  assign last      = (cnt == RES_CNT_W'(1));
  assign can_load  = (cnt == '0) || (last && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= group.count;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < RES_MAX; i++) begin
        q[i] <= group.item[i];
      end
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        q[i] <= q[i+1];
      end
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst, cnt <= RES_CNT_W'(RES_MAX))
  // a new group only lands once the previous one is gone
  `ASSERT_IMPLIES(a_load_when_free, clk, rst, load,
                  (cnt == '0) || ((cnt == RES_CNT_W'(1)) && pop))
  // draining keeps the result order
  `ASSERT_NEXT(a_shift_order, clk, rst, pop && !load && (cnt > RES_CNT_W'(1)),
               q[0] == $past(q[1]))

endmodule

@@ sv/json_string_unescape.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape: json string unescaper with utf-8 output
// a byte transfer lands in the input register; it is decoded into the result
//   register once that is free, and its first result is offered from there
// throughput: one byte per cycle unless stalled; n results take n transfers
// reset: synchronous, clears all control state, limit register set to all ones
// ----------------------------------------------------------------------------
module json_string_unescape import jsu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // source byte channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       source_byte,
  input  logic             end_of_source,
  input  logic             new_document,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             kind,
  output logic [7:0]       out_byte,
  output logic [3:0]       status,
  output logic             last,
  // decoded byte limit register
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // input register, one source byte deep
  logic             in_reg_valid;
  logic [7:0]       in_byte;
  logic             in_eos;
  logic             in_newdoc;

  logic             accept;
  logic             step;
  logic             can_load;
  logic [CFG_W-1:0] max_bytes;
  res_group_t       group;
  res_t             head;

  // the held byte is decoded as soon as the result register is free or
  // frees up this cycle, so the input side keeps moving while the last
  // result of the previous byte is still being taken
  assign step     = in_reg_valid && can_load;
  assign in_stall = in_reg_valid && !can_load;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (step) begin
      in_reg_valid <= 1'b0;
    end
  end

  // payload needs no reset, it is qualified by in_reg_valid
  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte   <= source_byte;
      in_eos    <= end_of_source;
      in_newdoc <= new_document;
    end
  end

  // limit on decoded bytes of escaped strings per document
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= '1;
    end else if (cfg_we) begin
      max_bytes <= cfg_wdata;
    end
  end

  // scanner, escape decoder and length bookkeeping; all results of one
  // byte come out as one group in the same cycle
  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (in_byte),
    .in_eos    (in_eos),
    .in_newdoc (in_newdoc),
    .max_bytes (max_bytes),
    .res       (group)
  );

  // result register; drains the group one transfer at a time
  jsu_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .group     (group),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .last      (last),
    .can_load  (can_load)
  );

  assign kind     = head.kind;
  assign out_byte = head.data;
  assign status   = head.status;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json string unescaper testbench
// drives source bytes of json strings, well formed with random content plus
// broken escapes and noise, under random idle and stall on both channels;
// a scoreboard class decodes every accepted byte itself and checks each
// result transfer in order, field by field
// ----------------------------------------------------------------------------
import jsu_pkg::*;

typedef struct {
  kind_t      kind;
  logic [7:0] data;
  status_t    status;
  bit         last;
} unescape_result_t;

class decode_scoreboard;
  logic [31:0]      limit;
  bit               in_string;
  bit               after_bslash;
  bit               has_escape;
  dmode_t           mode;
  int unsigned      digit_pos;
  logic [15:0]      digits;
  logic [9:0]       high_half;
  status_t          held_err;
  status_t          digit_err;
  logic [31:0]      raw_len;
  logic [31:0]      dec_len;
  logic [31:0]      doc_total;
  unescape_result_t due_results[$];
  unescape_result_t step_results[$];
  int               errors;

  function new();
    limit     = '1;
    in_string = 1'b0;
    doc_total = '0;
    errors    = 0;
    clear_string();
  endfunction

  function void clear_string();
    after_bslash = 1'b0;
    has_escape   = 1'b0;
    mode         = DM_PLAIN;
    digit_pos    = 0;
    digits       = '0;
    high_half    = '0;
    held_err     = ST_OK;
    digit_err    = ST_OK;
    raw_len      = '0;
    dec_len      = '0;
  endfunction

  function logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function void put_status(status_t s);
    unescape_result_t r;
    r = '{KIND_STATUS, 8'h00, s, 1'b0};
    step_results.insert(step_results.size(), r);
  endfunction

  function void emit_byte(logic [7:0] b);
    unescape_result_t r;
    r = '{KIND_BYTE, b, ST_OK, 1'b0};
    step_results.insert(step_results.size(), r);
    dec_len = sat_inc(dec_len);
  endfunction

  function void stop_decode(status_t s);
    held_err = s;
    mode     = DM_DEAD;
  endfunction

  // code point to utf-8, one to four bytes
  function void emit_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      emit_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit_byte({3'b110, cp[10:6]});
      emit_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit_byte({4'b1110, cp[15:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end else begin
      emit_byte({5'b11110, cp[20:18]});
      emit_byte({2'b10, cp[17:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end
  endfunction

  // first bad digit of an escape is remembered, good ones shift in
  function void take_digit(logic [7:0] b, status_t fault);
    logic [3:0] v;
    bit         ok;
    ok = 1'b1;
    v  = 4'd0;
    if (b >= CH_ZERO && b <= CH_NINE) v = 4'(b - CH_ZERO);
    else if (b >= CH_LA && b <= CH_LF) v = 4'(b - CH_LA + 8'd10);
    else if (b >= CH_UA && b <= CH_UF) v = 4'(b - CH_UA + 8'd10);
    else ok = 1'b0;
    if (!ok) begin
      if (digit_err == ST_OK) digit_err = fault;
    end else begin
      digits = {digits[11:0], v};
    end
  endfunction

  function void take_source_byte(logic [7:0] b, bit eos, bit nd);
    step_results.delete();
    if (nd) doc_total = '0;
    if (!in_string) begin
      if (!eos && b == CH_QUOTE) begin
        clear_string();
        in_string = 1'b1;
      end else begin
        put_status(ST_NO_QUOTE);
      end
    end else if (eos) begin
      put_status(after_bslash ? ST_OPEN_ESCAPE : ST_UNTERMINATED);
      in_string = 1'b0;
      clear_string();
    end else if (!after_bslash && b == CH_QUOTE) begin
      case (mode)
        DM_HEX:  stop_decode(ST_SHORT_UNI);
        DM_LOW:  stop_decode(ST_NO_LOW);
        DM_ESC:  stop_decode(ST_BAD_ESCAPE);
        default: ;
      endcase
      if (has_escape && (doc_total > limit || raw_len > limit - doc_total)) begin
        put_status(ST_LIMIT);
      end else begin
        put_status(held_err);
        if (held_err == ST_OK && has_escape)
          doc_total = (dec_len > ~doc_total) ? '1 : doc_total + dec_len;
      end
      in_string = 1'b0;
      clear_string();
    end else if (!after_bslash && b < CH_SPACE) begin
      put_status(ST_CONTROL);
      in_string = 1'b0;
      clear_string();
    end else begin
      if (after_bslash) begin
        after_bslash = 1'b0;
      end else if (b == CH_BSLASH) begin
        has_escape   = 1'b1;
        after_bslash = 1'b1;
      end
      raw_len = sat_inc(raw_len);
      case (mode)
        DM_PLAIN: begin
          if (b == CH_BSLASH) mode = DM_ESC;
          else emit_byte(b);
        end
        DM_ESC: begin
          mode = DM_PLAIN;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: emit_byte(b);
            CH_LB: emit_byte(CODE_BS);
            CH_LF: emit_byte(CODE_FF);
            CH_LN: emit_byte(CODE_LF);
            CH_LR: emit_byte(CODE_CR);
            CH_LT: emit_byte(CODE_TAB);
            CH_LU: begin
              mode      = DM_HEX;
              digit_pos = 0;
              digits    = '0;
              digit_err = ST_OK;
            end
            default: stop_decode(ST_BAD_ESCAPE);
          endcase
        end
        DM_HEX: begin
          take_digit(b, ST_BAD_HEX);
          digit_pos++;
          if (digit_pos >= 4) begin
            if (digit_err != ST_OK) begin
              stop_decode(digit_err);
            end else if (digits >= HI_SUR_FIRST && digits <= HI_SUR_LAST) begin
              high_half = digits[9:0];
              mode      = DM_LOW;
              digit_pos = 0;
              digits    = '0;
            end else if (digits >= LO_SUR_FIRST && digits <= LO_SUR_LAST) begin
              stop_decode(ST_LONE_LOW);
            end else begin
              emit_point({5'd0, digits});
              mode = DM_PLAIN;
            end
          end
        end
        DM_LOW: begin
          if ((digit_pos == 0 && b != CH_BSLASH) || (digit_pos == 1 && b != CH_LU)) begin
            stop_decode(ST_NO_LOW);
          end else begin
            if (digit_pos >= 2) take_digit(b, ST_BAD_LOW);
            digit_pos++;
            if (digit_pos >= 6) begin
              if (digit_err != ST_OK) begin
                stop_decode(digit_err);
              end else if (digits < LO_SUR_FIRST || digits > LO_SUR_LAST) begin
                stop_decode(ST_BAD_LOW);
              end else begin
                emit_point(SUPP_BASE + 21'({high_half, digits[9:0]}));
                mode = DM_PLAIN;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) due_results.insert(due_results.size(), step_results[i]);
  endfunction

  function void check_result(kind_t k, logic [7:0] d, status_t s, logic l);
    unescape_result_t e;
    if (due_results.size() == 0) begin
      $display("%0t: result with nothing due, kind %0d byte %h status %0d",
               $time, k, d, s);
      errors++;
      return;
    end
    e = due_results.pop_front();
    if (e.kind !== k) begin
      $display("%0t: kind mismatch, expected %0d, actual %0d", $time, e.kind, k);
      errors++;
    end
    if (e.data !== d) begin
      $display("%0t: out_byte mismatch, expected %h, actual %h", $time, e.data, d);
      errors++;
    end
    if (e.status !== s) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, s);
      errors++;
    end
    if (e.last !== l) begin
      $display("%0t: last mismatch, expected %0d, actual %0d", $time, e.last, l);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  // margin for a last transfer still passing the input and result registers
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 75;
  localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LB,
                                            CH_LF, CH_LN, CH_LR, CH_LT};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       source_byte = 8'h00;
  logic             end_of_source = 1'b0;
  logic             new_document = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             kind;
  logic [7:0]       out_byte;
  logic [3:0]       status;
  logic             last;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  decode_scoreboard decode_sb;
  logic [7:0]       src_bytes[$];
  int               items_sent = 0;
  int               cycle_count = 0;
  // set for strings sent back to back with no idle
  bit               quiet = 1'b0;
  int               stall_left = 0;
  bit               stall_val = 1'b0;
  int               stall_pick;

  json_string_unescape dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .source_byte   (source_byte),
    .end_of_source (end_of_source),
    .new_document  (new_document),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .out_byte      (out_byte),
    .status        (status),
    .last          (last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall: runs of free flow, short stalls and the odd long one
  always @(negedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 50) begin
          stall_val  = 1'b0;
          stall_left = $urandom_range(1, 12);
        end else if (stall_pick < 65) begin
          stall_val  = 1'b0;
          stall_left = $urandom_range(20, 60);
        end else if (stall_pick < 95) begin
          stall_val  = 1'b1;
          stall_left = $urandom_range(1, 3);
        end else begin
          stall_val  = 1'b1;
          stall_left = $urandom_range(10, 30);
        end
      end
      stall_left--;
      out_stall <= stall_val;
    end
  end

  // every result transfer goes straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      decode_sb.check_result(kind_t'(kind), out_byte, status_t'(status), last);
  end

  // run limit, well above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one source transfer: optional idle gap, then hold until not stalled
  task automatic send_item(input logic [7:0] b, input bit eos, input bit nd);
    int gap;
    int r;
    gap = 0;
    r   = $urandom_range(0, 99);
    if (!quiet) begin
      if (r >= 98) gap = $urandom_range(20, 40);
      else if (r >= 90) gap = $urandom_range(4, 10);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    source_byte   <= b;
    end_of_source <= eos;
    new_document  <= nd;
    do @(posedge clk); while (in_stall);
    decode_sb.take_source_byte(b, eos, nd);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, 1'b0);
  endtask

  // sender holds off until every due result has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decode_sb.due_results.size() != 0) @(posedge clk);
    // a last transfer with no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // append one byte to the string being built
  function automatic void add_byte(input logic [7:0] b);
    src_bytes.insert(src_bytes.size(), b);
  endfunction

  // backslash, u and four hex digits in random letter case
  function automatic void add_unicode(input logic [15:0] v);
    logic [3:0] n;
    add_byte(CH_BSLASH);
    add_byte(CH_LU);
    for (int i = 3; i >= 0; i--) begin
      n = v[i*4 +: 4];
      if (n < 4'd10) add_byte(CH_ZERO + 8'(n));
      else add_byte(($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(n) - 8'd10);
    end
  endfunction

  // one chunk of string content, mostly good, sometimes broken
  function automatic void add_piece();
    int          r;
    int          pos;
    logic [7:0]  c;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
      add_byte(c);
    end else if (r < 55) begin
      add_byte(CH_BSLASH);
      add_byte(SIMPLE_ESC[$urandom_range(0, 7)]);
    end else if (r < 70) begin
      // one, two and three byte utf-8 ranges, skipping surrogates
      case ($urandom_range(0, 3))
        0:       add_unicode(16'($urandom_range(0, 'h7F)));
        1:       add_unicode(16'($urandom_range('h80, 'h7FF)));
        2:       add_unicode(16'($urandom_range('h800, 'hD7FF)));
        default: add_unicode(16'($urandom_range('hE000, 'hFFFF)));
      endcase
    end else if (r < 82) begin
      add_unicode(16'($urandom_range('hD800, 'hDBFF)));
      add_unicode(16'($urandom_range('hDC00, 'hDFFF)));
    end else if (r < 85) begin
      // unknown escape letter, control bytes included
      add_byte(CH_BSLASH);
      c = 8'($urandom_range(0, 255));
      case (c)
        CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LB, CH_LF, CH_LN, CH_LR, CH_LT, CH_LU: c = CH_UA;
        default: ;
      endcase
      add_byte(c);
    end else if (r < 88) begin
      // one digit of a \u escape replaced by a non-hex byte
      add_unicode(16'($urandom()));
      pos = $urandom_range(0, 3);
      do c = 8'($urandom_range(32, 255));
      while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
             (c >= CH_UA && c <= CH_UF));
      src_bytes[src_bytes.size() - 4 + pos] = c;
    end else if (r < 91) begin
      // high surrogate with no low half of its own, left to whatever follows
      add_unicode(16'($urandom_range('hD800, 'hDBFF)));
    end else if (r < 94) begin
      // high surrogate followed by an escape that is not a low one
      add_unicode(16'($urandom_range('hD800, 'hDBFF)));
      do v = 16'($urandom()); while (v >= LO_SUR_FIRST && v <= LO_SUR_LAST);
      add_unicode(v);
    end else if (r < 96) begin
      add_unicode(16'($urandom_range('hDC00, 'hDFFF)));
    end else if (r < 98) begin
      // \u with fewer than four digits
      add_unicode(16'($urandom()));
      repeat ($urandom_range(1, 4)) src_bytes.delete(src_bytes.size() - 1);
    end else begin
      add_byte(8'($urandom_range(0, 31)));
    end
  endfunction

  // noise, then one string: quote, content chunks, and an ending
  task automatic send_random_string();
    int r;
    bit nd;
    if ($urandom_range(0, 99) < 8) begin
      if ($urandom_range(0, 1)) begin
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else begin
        r = $urandom_range(0, 255);
        send_item((8'(r) == CH_QUOTE) ? CH_SPACE : 8'(r), 1'b0, 1'b0);
      end
    end
    quiet = ($urandom_range(0, 4) == 0);
    src_bytes.delete();
    add_byte(CH_QUOTE);
    repeat ($urandom_range(0, 6)) add_piece();
    r = $urandom_range(0, 99);
    if (r < 92) add_byte(CH_QUOTE);
    foreach (src_bytes[i]) begin
      nd = (i == 0) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 99) < 3);
      send_item(src_bytes[i], 1'b0, nd);
    end
    // end of source inside the string, or left open for the next quote
    if (r >= 92 && r < 97) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  initial begin
    logic [31:0] limit_plan [4];
    decode_sb = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: faults at the raw level, the byte extremes, a few decode faults
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_text("\"");
    send_item(8'h01, 1'b0, 1'b0);
    send_text("\"\\");
    send_item(8'h00, 1'b1, 1'b0);
    send_text("\"a");
    send_item(8'hA5, 1'b1, 1'b0);
    send_text("\"\\q");
    send_item(CH_QUOTE, 1'b0, 1'b1);
    send_text("\"\\u12\"");
    send_text("\"\\udc00\"");
    drain_results();

    // limit settings: all ones, zero, tight enough to trip, moderate
    limit_plan[0] = '1;
    limit_plan[1] = '0;
    limit_plan[2] = 32'($urandom_range(8, 40));
    limit_plan[3] = 32'($urandom_range(60, 300));
    foreach (limit_plan[i]) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= limit_plan[i];
      @(negedge clk);
      cfg_we <= 1'b0;
      decode_sb.limit = limit_plan[i];
      while (items_sent < 28 + PHASE_ITEMS * (i + 1)) send_random_string();
      quiet = 1'b0;
      drain_results();
    end

    if (decode_sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
